// File: design/tvrs_pkg.sv
// Shared types, character codes and helpers for the text vector record scanner.
// No dependencies; imported by tvrs_scan_core and text_vector_record_scanner_unit.
package tvrs_pkg;

  localparam int OFFSET_BITS_DEF = 48;
  localparam int START_W         = 48;
  localparam int ID_W            = 64;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_DIGITS,
    PH_SEEK_OPEN,
    PH_AFTER_OPEN,
    PH_SEEK_CLOSE,
    PH_SKIP_LINE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_EOF    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OVERFLOW = 2'd0,
    ERR_NO_OPEN  = 2'd1,
    ERR_NO_CLOSE = 2'd2,
    ERR_BLANK    = 2'd3
  } err_t;

  typedef struct packed {
    logic               has;
    kind_t              kind;
    logic [ID_W-1:0]    record_id;
    logic [START_W-1:0] payload_offset;
    logic               deleted;
    err_t               error_code;
    logic               final_res;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage

// File: design/tvrs_scan_core.sv
// Per-byte line parser: phase, id accumulator, position and drop state.
// Depends on tvrs_pkg; instantiated by text_vector_record_scanner_unit.
module tvrs_scan_core
  import tvrs_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         byte_in,
  input  logic               end_of_file,
  input  logic               cfg_wr_en,
  input  logic [START_W-1:0] cfg_wr_data,
  output result_t            res
);

  logic [START_W-1:0]     start_offset;
  phase_t                 line_phase, line_phase_next;
  logic [ID_W-1:0]        id_accumulator, id_accumulator_next;
  logic                   id_overflowed, id_overflowed_next;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] latched_offset, latched_offset_next;
  logic                   payload_nonblank, payload_nonblank_next;
  logic                   drop_until_end;

  logic [OFFSET_BITS-1:0] pos_plus1;
  logic [7:0]             digit_diff;
  logic [ID_W+3:0]        acc_ext;
  logic                   acc_ovf;
  logic                   err, rec, rec_del;
  err_t                   ecode;
  logic [63:0]            start64, cfg64, lat64;

  assign pos_plus1  = byte_position + OFFSET_BITS'(1);
  assign digit_diff = byte_in - CH_ZERO;
  assign acc_ext    = ({4'b0, id_accumulator} << 3) + ({4'b0, id_accumulator} << 1)
                    + (ID_W+4)'(digit_diff[3:0]);
  assign acc_ovf    = |acc_ext[ID_W+3:ID_W];
  assign start64    = 64'(start_offset);
  assign cfg64      = 64'(cfg_wr_data);
  assign lat64      = 64'(latched_offset);

  always_comb begin
    line_phase_next       = line_phase;
    id_accumulator_next   = id_accumulator;
    id_overflowed_next    = id_overflowed;
    latched_offset_next   = latched_offset;
    payload_nonblank_next = payload_nonblank;
    err     = 1'b0;
    ecode   = ERR_OVERFLOW;
    rec     = 1'b0;
    rec_del = 1'b0;

    case (line_phase)
      PH_LEAD: begin
        if (byte_in == CH_NL || is_blank(byte_in)) begin
          line_phase_next = PH_LEAD;
        end else if (is_digit(byte_in)) begin
          id_accumulator_next = ID_W'(digit_diff[3:0]);
          id_overflowed_next  = 1'b0;
          line_phase_next     = PH_DIGITS;
        end else begin
          line_phase_next = PH_SKIP_LINE;
        end
      end
      PH_DIGITS: begin
        if (is_digit(byte_in)) begin
          if (!id_overflowed) begin
            if (acc_ovf) begin
              id_overflowed_next = 1'b1;
            end else begin
              id_accumulator_next = acc_ext[ID_W-1:0];
            end
          end
        end else if (id_overflowed) begin
          err = 1'b1; ecode = ERR_OVERFLOW;
        end else if (byte_in == CH_NL) begin
          err = 1'b1; ecode = ERR_NO_OPEN;
        end else if (byte_in == CH_OPEN) begin
          latched_offset_next = pos_plus1;
          line_phase_next     = PH_AFTER_OPEN;
        end else begin
          line_phase_next = PH_SEEK_OPEN;
        end
      end
      PH_SEEK_OPEN: begin
        if (byte_in == CH_NL) begin
          err = 1'b1; ecode = ERR_NO_OPEN;
        end else if (byte_in == CH_OPEN) begin
          latched_offset_next = pos_plus1;
          line_phase_next     = PH_AFTER_OPEN;
        end
      end
      PH_AFTER_OPEN: begin
        if (byte_in == CH_CLOSE) begin
          rec = 1'b1; rec_del = 1'b1;
        end else if (byte_in == CH_NL) begin
          err = 1'b1; ecode = ERR_NO_CLOSE;
        end else begin
          payload_nonblank_next = !is_blank(byte_in);
          line_phase_next       = PH_SEEK_CLOSE;
        end
      end
      PH_SEEK_CLOSE: begin
        if (byte_in == CH_CLOSE) begin
          if (payload_nonblank) begin
            rec = 1'b1;
          end else begin
            err = 1'b1; ecode = ERR_BLANK;
          end
        end else if (byte_in == CH_NL) begin
          err = 1'b1; ecode = ERR_NO_CLOSE;
        end else if (!is_blank(byte_in)) begin
          payload_nonblank_next = 1'b1;
        end
      end
      default: begin
        line_phase_next = (byte_in == CH_NL) ? PH_LEAD : PH_SKIP_LINE;
      end
    endcase

    // unfinished line at end of file
    if (!err && !rec && end_of_file) begin
      if (line_phase_next == PH_DIGITS) begin
        err   = 1'b1;
        ecode = id_overflowed_next ? ERR_OVERFLOW : ERR_NO_OPEN;
      end else if (line_phase_next == PH_SEEK_OPEN) begin
        err = 1'b1; ecode = ERR_NO_OPEN;
      end else if (line_phase_next == PH_AFTER_OPEN
                   || line_phase_next == PH_SEEK_CLOSE) begin
        err = 1'b1; ecode = ERR_NO_CLOSE;
      end
    end

    if (rec) begin
      line_phase_next       = PH_SKIP_LINE;
      payload_nonblank_next = 1'b0;
    end

    res                = '0;
    res.kind           = KIND_RECORD;
    res.error_code     = ERR_OVERFLOW;
    if (!drop_until_end) begin
      if (rec) begin
        res.has            = 1'b1;
        res.kind           = KIND_RECORD;
        res.record_id      = id_accumulator;
        res.payload_offset = lat64[START_W-1:0];
        res.deleted        = rec_del;
        res.final_res      = end_of_file;
      end else if (err) begin
        res.has        = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ecode;
        res.final_res  = 1'b1;
      end else if (end_of_file) begin
        res.has       = 1'b1;
        res.kind      = KIND_EOF;
        res.final_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset     <= '0;
      line_phase       <= PH_LEAD;
      id_accumulator   <= '0;
      id_overflowed    <= 1'b0;
      byte_position    <= '0;
      latched_offset   <= '0;
      payload_nonblank <= 1'b0;
      drop_until_end   <= 1'b0;
    end else if (cfg_wr_en) begin
      start_offset     <= cfg_wr_data;
      line_phase       <= PH_LEAD;
      id_accumulator   <= '0;
      id_overflowed    <= 1'b0;
      byte_position    <= cfg64[OFFSET_BITS-1:0];
      latched_offset   <= '0;
      payload_nonblank <= 1'b0;
      drop_until_end   <= 1'b0;
    end else if (step) begin
      if (end_of_file) begin
        line_phase       <= PH_LEAD;
        id_accumulator   <= '0;
        id_overflowed    <= 1'b0;
        byte_position    <= start64[OFFSET_BITS-1:0];
        latched_offset   <= '0;
        payload_nonblank <= 1'b0;
        drop_until_end   <= 1'b0;
      end else begin
        byte_position <= pos_plus1;
        if (!drop_until_end) begin
          line_phase       <= line_phase_next;
          id_accumulator   <= id_accumulator_next;
          id_overflowed    <= id_overflowed_next;
          latched_offset   <= latched_offset_next;
          payload_nonblank <= payload_nonblank_next;
          drop_until_end   <= err;
        end
      end
    end
  end

endmodule

// File: design/text_vector_record_scanner_unit.sv
// A result passes the input register and then the result register on its way out.
// Throughput: one byte per cycle unless the input register stalls; the next byte may follow while a result waits.
// The input register stalls only when the result register is full and not taken
// and the held byte makes a result.
// Reset (rst, synchronous): clears start_offset, parser state and both valid flags.
// A start_offset write restarts parsing as for a new file.
module text_vector_record_scanner_unit
  import tvrs_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         byte_in,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [ID_W-1:0]    record_id,
  output logic [START_W-1:0] payload_offset,
  output logic               deleted,
  output logic [1:0]         error_code,
  output logic               final_res,
  input  logic               cfg_wr_en,
  input  logic [START_W-1:0] cfg_wr_data
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eof;
  logic       s1_go;
  result_t    res;

  tvrs_scan_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_go),
    .byte_in     (s1_byte),
    .end_of_file (s1_eof),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res         (res)
  );

  // a byte with no result moves on even while the result register is held
  assign s1_go    = s1_valid && (!out_valid || out_ready || !res.has);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= byte_in;
      s1_eof  <= end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res.has) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.has) begin
      kind           <= res.kind;
      record_id      <= res.record_id;
      payload_offset <= res.payload_offset;
      deleted        <= res.deleted;
      error_code     <= res.error_code;
      final_res      <= res.final_res;
    end
  end

`ifndef ASSERT_OFF
  a_error_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_ERROR) |-> final_res)
    else $error("error result without final flag");

  a_eof_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_EOF) |-> final_res)
    else $error("end of file result without final flag");

  a_nonrecord_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_RECORD) |->
      (record_id == '0 && payload_offset == '0 && deleted == 1'b0))
    else $error("record fields set on non-record result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a held result");
`endif

endmodule

// File: dv/tb_text_vector_record_scanner_unit.sv
// Testbench for text_vector_record_scanner_unit: directed byte table, then random text files.
// Checks every result transfer against an in-bench scanner predictor or a pinned row's expectation; needs tvrs_pkg.
module tb_text_vector_record_scanner_unit;
  import tvrs_pkg::*;

  localparam int LIMIT  = 200000;
  localparam int SETTLE = 4;
  localparam int PHASE_BYTES = 180;
  localparam string MAX_ID  = "18446744073709551615";
  localparam string OVER_ID = "18446744073709551616";
  localparam result_t NO_RES = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       eof;
    logic       pinned;
    result_t    exp;
  } row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         byte_in = '0;
  logic               end_of_file = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         kind;
  logic [ID_W-1:0]    record_id;
  logic [START_W-1:0] payload_offset;
  logic               deleted;
  logic [1:0]         error_code;
  logic               final_res;
  logic               cfg_wr_en = 1'b0;
  logic [START_W-1:0] cfg_wr_data = '0;

  logic    pin_row = 1'b0;
  result_t pin_exp = '0;

  // scanner predictor state
  phase_t             scan_phase;
  logic [ID_W-1:0]    id_acc;
  logic               id_ovf;
  logic [START_W-1:0] cur_pos;
  logic [START_W-1:0] open_pos;
  logic [START_W-1:0] start_reg;
  logic               saw_text;
  logic               dropping;

  result_t    due_results[$];
  row_t       dir_rows[25];
  logic [7:0] fbytes[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int n_bad = 0;
  int n_rec = 0;
  int n_eof = 0;
  int n_err = 0;
  int random_bytes = 0;

  text_vector_record_scanner_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .byte_in(byte_in),
    .end_of_file(end_of_file),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .record_id(record_id),
    .payload_offset(payload_offset),
    .deleted(deleted),
    .error_code(error_code),
    .final_res(final_res),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void file_restart();
    scan_phase = PH_LEAD;
    id_acc     = '0;
    id_ovf     = 1'b0;
    cur_pos    = start_reg;
    open_pos   = '0;
    saw_text   = 1'b0;
    dropping   = 1'b0;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] c, input logic eof);
    result_t    res;
    logic       rec;
    logic       del;
    logic       bad;
    err_t       code;
    logic [67:0] wide;
    res  = '0;
    rec  = 1'b0;
    del  = 1'b0;
    bad  = 1'b0;
    code = ERR_OVERFLOW;
    if (!dropping) begin
      case (scan_phase)
        PH_LEAD: begin
          if (digit_char(c)) begin
            id_acc     = 64'(c[3:0]);
            id_ovf     = 1'b0;
            scan_phase = PH_DIGITS;
          end else if (!(c == CH_NL || blank_char(c))) begin
            scan_phase = PH_SKIP_LINE;
          end
        end
        PH_DIGITS: begin
          if (digit_char(c)) begin
            if (!id_ovf) begin
              wide = {4'd0, id_acc} * 68'd10 + 68'(c[3:0]);
              if (wide[67:64] != 4'd0) id_ovf = 1'b1;
              else id_acc = wide[63:0];
            end
          end else if (id_ovf) begin
            bad  = 1'b1;
            code = ERR_OVERFLOW;
          end else if (c == CH_NL) begin
            bad  = 1'b1;
            code = ERR_NO_OPEN;
          end else if (c == CH_OPEN) begin
            open_pos   = cur_pos + 1'b1;
            scan_phase = PH_AFTER_OPEN;
          end else begin
            scan_phase = PH_SEEK_OPEN;
          end
        end
        PH_SEEK_OPEN: begin
          if (c == CH_NL) begin
            bad  = 1'b1;
            code = ERR_NO_OPEN;
          end else if (c == CH_OPEN) begin
            open_pos   = cur_pos + 1'b1;
            scan_phase = PH_AFTER_OPEN;
          end
        end
        PH_AFTER_OPEN: begin
          if (c == CH_CLOSE) begin
            rec = 1'b1;
            del = 1'b1;
          end else if (c == CH_NL) begin
            bad  = 1'b1;
            code = ERR_NO_CLOSE;
          end else begin
            saw_text   = !blank_char(c);
            scan_phase = PH_SEEK_CLOSE;
          end
        end
        PH_SEEK_CLOSE: begin
          if (c == CH_CLOSE) begin
            if (saw_text) begin
              rec = 1'b1;
            end else begin
              bad  = 1'b1;
              code = ERR_BLANK;
            end
          end else if (c == CH_NL) begin
            bad  = 1'b1;
            code = ERR_NO_CLOSE;
          end else if (!blank_char(c)) begin
            saw_text = 1'b1;
          end
        end
        default: begin
          scan_phase = (c == CH_NL) ? PH_LEAD : PH_SKIP_LINE;
        end
      endcase

      // end of file also closes the current line
      if (!bad && !rec && eof) begin
        if (scan_phase == PH_DIGITS) begin
          bad = 1'b1;
          if (id_ovf) code = ERR_OVERFLOW;
          else code = ERR_NO_OPEN;
        end else if (scan_phase == PH_SEEK_OPEN) begin
          bad  = 1'b1;
          code = ERR_NO_OPEN;
        end else if (scan_phase == PH_AFTER_OPEN || scan_phase == PH_SEEK_CLOSE) begin
          bad  = 1'b1;
          code = ERR_NO_CLOSE;
        end
      end

      if (rec) begin
        res.has            = 1'b1;
        res.kind           = KIND_RECORD;
        res.record_id      = id_acc;
        res.payload_offset = open_pos;
        res.deleted        = del;
        res.final_res      = eof;
        scan_phase         = PH_SKIP_LINE;
        saw_text           = 1'b0;
      end else if (bad) begin
        res.has        = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = code;
        res.final_res  = 1'b1;
        dropping       = 1'b1;
      end else if (eof) begin
        res.has       = 1'b1;
        res.kind      = KIND_EOF;
        res.final_res = 1'b1;
      end
    end
    if (eof) file_restart();
    else cur_pos = cur_pos + 1'b1;
    return res;
  endfunction

  function automatic result_t mk_res(input kind_t k, input logic [ID_W-1:0] id,
                                     input logic [START_W-1:0] off, input logic del,
                                     input err_t e, input logic fin);
    result_t r;
    r.has            = 1'b1;
    r.kind           = k;
    r.record_id      = id;
    r.payload_offset = off;
    r.deleted        = del;
    r.error_code     = e;
    r.final_res      = fin;
    return r;
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VT;
      3: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] text_byte(input logic close_ok);
    logic [7:0] b;
    do begin
      b = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(32, 126));
    end while (b == CH_NL || (!close_ok && b == CH_CLOSE));
    return b;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    fbytes.insert(fbytes.size(), b);
  endfunction

  // monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin
    result_t pred;
    result_t want;
    if (rst) begin
      start_reg = '0;
      file_restart();
      due_results.delete();
    end else begin
      if (cfg_wr_en) begin
        start_reg = cfg_wr_data;
        file_restart();
      end
      if (in_valid && in_ready) begin
        pred = parse_byte(byte_in, end_of_file);
        if (pin_row) pred = pin_exp;
        if (pred.has) due_results.insert(due_results.size(), pred);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d", kind);
          n_bad++;
        end else begin
          want = due_results.pop_front();
          case (want.kind)
            KIND_RECORD: n_rec++;
            KIND_EOF:    n_eof++;
            default:     n_err++;
          endcase
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            n_bad++;
          end
          if (record_id !== want.record_id) begin
            $error("record_id: expected %0d, got %0d", want.record_id, record_id);
            n_bad++;
          end
          if (payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %h, got %h", want.payload_offset, payload_offset);
            n_bad++;
          end
          if (deleted !== want.deleted) begin
            $error("deleted: expected %0d, got %0d", want.deleted, deleted);
            n_bad++;
          end
          if (error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, error_code);
            n_bad++;
          end
          if (final_res !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, final_res);
            n_bad++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", LIMIT, due_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eof, input logic pinned,
                           input result_t exp);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    byte_in     <= b;
    end_of_file <= eof;
    pin_row     <= pinned;
    pin_exp     <= exp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one random file: mostly well-formed record lines, some broken lines and noise
  task automatic send_file();
    int    sel;
    int    n;
    string s;
    fbytes.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        sel = $urandom_range(99);
        repeat ($urandom_range(0, 2)) add_byte(($urandom_range(3) == 0) ? CH_NL : any_blank());
        if (sel < 8) begin
          do s = ""; while (0);
          add_byte("#");
          repeat ($urandom_range(0, 8)) add_byte(text_byte(1'b1));
          add_byte(CH_NL);
        end else begin
          n = $urandom_range(99);
          if (n < 9) begin
            s = (n < 6) ? MAX_ID : OVER_ID;
            for (int i = 0; i < s.len(); i++) add_byte(s[i]);
          end else begin
            repeat ((n < 13) ? $urandom_range(20, 21) : $urandom_range(1, 5))
              add_byte(CH_ZERO + 8'($urandom_range(9)));
          end
          repeat ($urandom_range(0, 2)) add_byte($urandom_range(1) ? CH_SPACE : ":");
          if (sel < 12) begin
            add_byte(CH_NL);
          end else begin
            add_byte(CH_OPEN);
            if (sel < 16) begin
              repeat ($urandom_range(0, 4)) add_byte(text_byte(1'b0));
            end else begin
              if (sel < 20) repeat ($urandom_range(1, 3)) add_byte(any_blank());
              else if (sel >= 40) repeat ($urandom_range(1, 8)) add_byte(text_byte(1'b0));
              add_byte(CH_CLOSE);
              repeat ($urandom_range(0, 3)) add_byte(text_byte(1'b1));
            end
            add_byte(CH_NL);
          end
        end
      end
      // let end of file land on the closing bracket or tail now and then
      if ($urandom_range(2) == 0 && fbytes.size() > 1) void'(fbytes.pop_back());
    end
    for (int i = 0; i < fbytes.size(); i++) begin
      push_byte(fbytes[i], i == fbytes.size() - 1, 1'b0, NO_RES);
      random_bytes++;
    end
  endtask

  initial begin
    int                 goal;
    logic               paused;
    logic [START_W-1:0] start_val;

    // start_offset is 0 after reset; pinned rows are read straight off the line format
    dir_rows = '{
      '{CH_SPACE, 1'b0, 1'b0, NO_RES},
      '{CH_TAB,   1'b0, 1'b0, NO_RES},
      '{CH_VT,    1'b0, 1'b0, NO_RES},
      '{CH_FF,    1'b0, 1'b0, NO_RES},
      '{CH_CR,    1'b0, 1'b0, NO_RES},
      '{"#",      1'b0, 1'b0, NO_RES},
      '{CH_NL,    1'b0, 1'b0, NO_RES},
      '{"0",      1'b0, 1'b0, NO_RES},
      '{CH_SPACE, 1'b0, 1'b0, NO_RES},
      '{CH_OPEN,  1'b0, 1'b0, NO_RES},
      '{"x",      1'b0, 1'b0, NO_RES},
      '{CH_CLOSE, 1'b0, 1'b1, mk_res(KIND_RECORD, 64'd0, 48'd10, 1'b0, ERR_OVERFLOW, 1'b0)},
      '{"9",      1'b0, 1'b0, NO_RES},
      '{CH_NL,    1'b0, 1'b0, NO_RES},
      '{"5",      1'b0, 1'b0, NO_RES},
      '{CH_OPEN,  1'b0, 1'b0, NO_RES},
      '{CH_CLOSE, 1'b1, 1'b1, mk_res(KIND_RECORD, 64'd5, 48'd16, 1'b1, ERR_OVERFLOW, 1'b1)},
      '{"1",      1'b0, 1'b0, NO_RES},
      '{CH_NL,    1'b0, 1'b1, mk_res(KIND_ERROR, '0, '0, 1'b0, ERR_NO_OPEN, 1'b1)},
      '{"x",      1'b1, 1'b1, NO_RES},
      '{"2",      1'b0, 1'b0, NO_RES},
      '{CH_OPEN,  1'b0, 1'b0, NO_RES},
      '{CH_SPACE, 1'b0, 1'b0, NO_RES},
      '{CH_CLOSE, 1'b1, 1'b1, mk_res(KIND_ERROR, '0, '0, 1'b0, ERR_BLANK, 1'b1)},
      '{CH_NL,    1'b1, 1'b1, mk_res(KIND_EOF, '0, '0, 1'b0, ERR_OVERFLOW, 1'b1)}
    };

    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      push_byte(dir_rows[i].b, dir_rows[i].eof, dir_rows[i].pinned, dir_rows[i].exp);

    for (int p = 0; p < 4; p++) begin
      wait_drain();
      case (p)
        0: start_val = '1;
        1: start_val = {16'($urandom), 32'($urandom)};
        2: start_val = 48'hFFFF_FFFF_FFF8;
        default: start_val = '0;
      endcase
      cfg_wr_data <= start_val;
      cfg_wr_en   <= 1'b1;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      case (p)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 48; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 48; end
        default: begin idle_pct = 9; stall_pct <= 9; end
      endcase
      // long receiver hold-off while the sender keeps offering bytes
      if (p == 0) hold_left <= 300;
      goal   = random_bytes + PHASE_BYTES;
      paused = (p != 3);
      while (random_bytes < goal) begin
        send_file();
        if (!paused && random_bytes >= goal - PHASE_BYTES / 2) begin
          wait_drain();
          paused = 1'b1;
        end
      end
    end
    wait_drain();

    $display("scanned %0d directed and %0d random bytes under four handshake mixes",
             $size(dir_rows), random_bytes);
    $display("checked %0d records, %0d end-of-file and %0d error results", n_rec, n_eof, n_err);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: text_vector_record_scanner_unit.f
design/tvrs_pkg.sv
design/tvrs_scan_core.sv
design/text_vector_record_scanner_unit.sv
dv/tb_text_vector_record_scanner_unit.sv
